[rtl/cubic_hermite_resampler_defines.svh]
// Assertion helpers shared by the checker file.
`ifndef CUBIC_HERMITE_RESAMPLER_DEFINES_SVH
`define CUBIC_HERMITE_RESAMPLER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/chr_pkg.sv]
package chr_pkg;

  localparam int CHR_MAX_LEN     = 4096;
  localparam int CHR_FRAC_BITS   = 16;
  localparam int CHR_SAMPLE_BITS = 16;
  localparam int CHR_MAX_RESULTS = 33;
  localparam int CHR_STEP_W      = 28;
  localparam int CHR_COUNT_W     = 16;
  localparam int CHR_CFG_IDX_W   = 2;
  localparam int CHR_CFG_DATA_W  = 28;
  localparam int CHR_STEP_RESET  = 65536;
  localparam int CHR_COUNT_RESET = 1;
  // headroom above the sample width for the doubled cubic coefficients
  localparam int CHR_GROW        = 6;

  typedef enum logic [CHR_CFG_IDX_W-1:0] {
    CFG_STEP  = 2'd0,
    CFG_COUNT = 2'd1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_COEF,
    ST_MUL0,
    ST_ACC0,
    ST_MUL1,
    ST_ACC1,
    ST_MUL2,
    ST_ACC2,
    ST_EMIT
  } state_t;

endpackage

[rtl/chr_kernel.sv]
module chr_kernel #(
  parameter int SAMPLE_BITS = chr_pkg::CHR_SAMPLE_BITS,
  parameter int IDX_W       = 12,
  parameter int CNT_W       = 13,
  parameter int W           = chr_pkg::CHR_SAMPLE_BITS + chr_pkg::CHR_GROW
) (
  input  logic signed [SAMPLE_BITS-1:0] window [4],
  input  logic        [IDX_W-1:0]       idx,
  input  logic        [CNT_W-1:0]       cnt,
  output logic signed [W-1:0]           y1,
  output logic signed [W-1:0]           a0,
  output logic signed [W-1:0]           a1,
  output logic signed [W-1:0]           a2
);

  localparam int J_W = CNT_W + 2;

  logic signed [J_W-1:0] idx_s;
  logic signed [J_W-1:0] cnt_s;
  logic signed [J_W-1:0] last_s;
  logic signed [J_W-1:0] j_v [4];
  logic signed [J_W-1:0] s_v [4];
  logic signed [W-1:0]   ye  [4];

  assign idx_s  = $signed({{(J_W-IDX_W){1'b0}}, idx});
  assign cnt_s  = $signed({2'b00, cnt});
  assign last_s = cnt_s - J_W'(1);

  // Clamp each tap to the frame, then map the frame index onto the window slot.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      j_v[k] = idx_s + J_W'(k - 1);
      if (j_v[k] > last_s) j_v[k] = last_s;
      if (j_v[k] < 0) j_v[k] = '0;
      s_v[k] = j_v[k] - cnt_s + J_W'(4);
      if (s_v[k] < 0) s_v[k] = '0;
      if (s_v[k] > J_W'(3)) s_v[k] = J_W'(3);
      ye[k] = W'(window[s_v[k][1:0]]);
    end
  end

  assign y1 = ye[1];
  assign a0 = ye[3] - ye[0] + ((ye[1] - ye[2]) <<< 1) + (ye[1] - ye[2]);
  assign a1 = (ye[0] <<< 1) - ((ye[1] <<< 2) + ye[1]) + (ye[2] <<< 2) - ye[3];
  assign a2 = ye[2] - ye[0];

endmodule

[rtl/chr_mul.sv]
module chr_mul #(
  parameter int W         = chr_pkg::CHR_SAMPLE_BITS + chr_pkg::CHR_GROW,
  parameter int FRAC_BITS = chr_pkg::CHR_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [W-1:0]         op_a,
  input  logic        [FRAC_BITS-1:0] mu,
  output logic signed [W+FRAC_BITS:0] prod_r
);

  logic signed [FRAC_BITS:0] mu_s;

  assign mu_s = $signed({1'b0, mu});

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_a * mu_s;
    end
  end

endmodule

[rtl/cubic_hermite_resampler.sv]
// Streaming Catmull-Rom resampler. Samples of one frame arrive one request at a
// time, the last with in_frame_end; each request yields zero to 33 interpolated
// results at a read position that advances by step_q16 per result (steps below
// 1/16 count as 1/16). One multiplier is shared by the three Horner steps, so
// a request's results are worked out one after another, and the output side
// can stall each of them; in_ready is low while a request is being worked on.
// Write the registers only while the block is idle.
module cubic_hermite_resampler #(
  parameter int MAX_LEN     = chr_pkg::CHR_MAX_LEN,
  parameter int FRAC_BITS   = chr_pkg::CHR_FRAC_BITS,
  parameter int SAMPLE_BITS = chr_pkg::CHR_SAMPLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  input  logic                                in_frame_end,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       out_value,
  output logic                                out_clipped,
  output logic                                out_frame_done,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [chr_pkg::CHR_CFG_IDX_W-1:0]   cfg_index,
  input  logic [chr_pkg::CHR_CFG_DATA_W-1:0]  cfg_data
);

  import chr_pkg::*;

  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int POS_W = IDX_W + FRAC_BITS;
  localparam int W     = SAMPLE_BITS + CHR_GROW;
  localparam int PW    = W + FRAC_BITS + 1;
  localparam int N_W   = $clog2(CHR_MAX_RESULTS + 1);
  localparam int SUM_W = ((POS_W > CHR_STEP_W) ? POS_W : CHR_STEP_W) + 1;

  localparam logic [POS_W-1:0] POS_MAX = {IDX_W'(MAX_LEN - 1), {FRAC_BITS{1'b1}}};
  localparam logic [CHR_STEP_W-1:0] STEP_MIN = CHR_STEP_W'(64'd1 << (FRAC_BITS - 4));
  localparam logic signed [PW-1:0] RND_HALF =
    {{(PW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [W-1:0] SMAX = {{(W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {{(W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

  state_t state_r, state_nxt;

  logic signed [SAMPLE_BITS-1:0] window_r [4];
  logic [POS_W-1:0]        pos_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [CHR_COUNT_W-1:0]  done_r;
  logic [N_W-1:0]          n_r;
  logic                    end_r;
  logic [CHR_STEP_W-1:0]   step_r;
  logic [CHR_COUNT_W-1:0]  count_r;
  logic signed [W-1:0]     y1_r, a0_r, a1_r, a2_r, t_r, v_r;
  logic                    out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_value_r;
  logic                    out_clipped_r;
  logic                    out_frame_done_r;

  logic signed [W-1:0]     y1_k, a0_k, a1_k, a2_k;
  logic signed [PW-1:0]    prod_r;
  logic signed [PW-1:0]    rnd_sum;
  logic                    mul_en;
  logic signed [W-1:0]     mul_op;
  logic [IDX_W-1:0]        idx;
  logic [CNT_W:0]          idx_p3;
  logic                    go;
  logic                    out_free;
  logic                    accept;
  logic                    last_out;
  logic                    sat_hi, sat_lo;
  logic [CHR_STEP_W-1:0]   step_eff;
  logic [SUM_W-1:0]        pos_sum;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_ready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free = !out_valid_r || out_ready;

  assign idx    = pos_r[POS_W-1:FRAC_BITS];
  assign idx_p3 = (CNT_W+1)'(idx) + (CNT_W+1)'(3);
  assign go     = (done_r < count_r) && (n_r < N_W'(CHR_MAX_RESULTS)) &&
                  (end_r || (idx_p3 <= {1'b0, cnt_r}));

  assign last_out = (({1'b0, done_r} + (CHR_COUNT_W+1)'(1)) >= {1'b0, count_r}) ||
                    (end_r && (n_r == N_W'(CHR_MAX_RESULTS - 1)));

  assign sat_hi = (v_r > SMAX);
  assign sat_lo = (v_r < SMIN);

  assign step_eff = (step_r < STEP_MIN) ? STEP_MIN : step_r;
  assign pos_sum  = SUM_W'(pos_r) + SUM_W'(step_eff);

  assign rnd_sum = prod_r + RND_HALF;

  assign mul_en = (state_r == ST_MUL0) || (state_r == ST_MUL1) || (state_r == ST_MUL2);
  assign mul_op = (state_r == ST_MUL0) ? a0_r : t_r;

  chr_kernel #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W),
    .W          (W)
  ) u_kernel (
    .window(window_r),
    .idx   (idx),
    .cnt   (cnt_r),
    .y1    (y1_k),
    .a0    (a0_k),
    .a1    (a1_k),
    .a2    (a2_k)
  );

  chr_mul #(
    .W        (W),
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk   (clk),
    .en    (mul_en),
    .op_a  (mul_op),
    .mu    (pos_r[FRAC_BITS-1:0]),
    .prod_r(prod_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = go ? ST_COEF : ST_IDLE;
      ST_COEF:  state_nxt = ST_MUL0;
      ST_MUL0:  state_nxt = ST_ACC0;
      ST_ACC0:  state_nxt = ST_MUL1;
      ST_MUL1:  state_nxt = ST_ACC1;
      ST_ACC1:  state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = ST_ACC2;
      ST_ACC2:  state_nxt = ST_EMIT;
      ST_EMIT:  if (out_free) state_nxt = ST_CHECK;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Frame state, counters and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= '{default: '0};
      pos_r       <= '0;
      cnt_r       <= '0;
      done_r      <= '0;
      n_r         <= '0;
      end_r       <= 1'b0;
      step_r      <= CHR_STEP_W'(CHR_STEP_RESET);
      count_r     <= CHR_COUNT_W'(CHR_COUNT_RESET);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_STEP:  step_r  <= cfg_data[CHR_STEP_W-1:0];
          CFG_COUNT: count_r <= cfg_data[CHR_COUNT_W-1:0];
          default:   ;
        endcase
      end

      if (out_valid_r && out_ready && !((state_r == ST_EMIT) && out_free)) begin
        out_valid_r <= 1'b0;
      end

      if (accept) begin
        window_r[0] <= window_r[1];
        window_r[1] <= window_r[2];
        window_r[2] <= window_r[3];
        window_r[3] <= in_sample;
        cnt_r       <= cnt_r + CNT_W'(1);
        end_r       <= in_frame_end || (cnt_r == CNT_W'(MAX_LEN - 1));
        n_r         <= '0;
      end

      // Drop the frame once its last request has produced what it can.
      if ((state_r == ST_CHECK) && !go && end_r) begin
        window_r <= '{default: '0};
        pos_r    <= '0;
        cnt_r    <= '0;
        done_r   <= '0;
      end

      if ((state_r == ST_EMIT) && out_free) begin
        out_valid_r <= 1'b1;
        done_r      <= done_r + CHR_COUNT_W'(1);
        n_r         <= n_r + N_W'(1);
        if (pos_sum > SUM_W'(POS_MAX)) begin
          pos_r <= POS_MAX;
        end else begin
          pos_r <= pos_sum[POS_W-1:0];
        end
      end
    end
  end

  // Horner datapath around the shared multiplier.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_COEF: begin
        y1_r <= y1_k;
        a0_r <= a0_k;
        a1_r <= a1_k;
        a2_r <= a2_k;
      end
      ST_ACC0: t_r <= W'(prod_r >>> FRAC_BITS) + a1_r;
      ST_ACC1: t_r <= W'(prod_r >>> FRAC_BITS) + a2_r;
      ST_ACC2: v_r <= y1_r + W'(rnd_sum >>> (FRAC_BITS + 1));
      ST_EMIT: begin
        if (out_free) begin
          out_value_r      <= sat_hi ? SMAX[SAMPLE_BITS-1:0] :
                              sat_lo ? SMIN[SAMPLE_BITS-1:0] : v_r[SAMPLE_BITS-1:0];
          out_clipped_r    <= sat_hi || sat_lo;
          out_frame_done_r <= last_out;
        end
      end
      default: ;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_clipped    = out_clipped_r;
  assign out_frame_done = out_frame_done_r;

endmodule

[rtl/chr_checker.sv]
`include "cubic_hermite_resampler_defines.svh"

module chr_checker #(
  parameter int SAMPLE_BITS = chr_pkg::CHR_SAMPLE_BITS
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] out_value,
  input logic                          out_clipped,
  input logic                          out_frame_done
);

  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // A stalled result holds.
  `CHR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_clipped) && $stable(out_frame_done), "stalled result changed")

  // An accepted request keeps the block busy for at least the next cycle.
  `CHR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "ready right after accept")

  // A clipped result sits at one of the saturation limits.
  `CHR_ASSERT_SAME(a_clip_at_limit, clk, rst_n, out_valid && out_clipped, (out_value == SMAX) || (out_value == SMIN), "clipped result not at a limit")

endmodule

bind cubic_hermite_resampler chr_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_chr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_value     (out_value),
  .out_clipped   (out_clipped),
  .out_frame_done(out_frame_done)
);
